[design/lcf_pkg.sv]
package lcf_pkg;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_byte;
   } req_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       frame_end;
      logic       busy_res;
      logic       char_dropped;
   } rsp_type;

   localparam logic [1:0] MODE_CHAR  = 2'd0;
   localparam logic [1:0] MODE_EOL   = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic [7:0]  CH_LF      = 8'h0A;
   localparam logic [7:0]  CH_CR      = 8'h0D;
   localparam logic [7:0]  DELIM      = 8'h55;
   localparam logic [7:0]  MAGIC_HI   = 8'h50;
   localparam logic [7:0]  MAGIC_LO   = 8'h21;
   localparam logic [7:0]  PROTO_HI   = 8'h00;
   localparam logic [7:0]  PROTO_LO   = 8'h03;
   localparam int          MSG_OFFSET = 35;
   localparam int          LEN_BIAS   = 33;
   localparam int          RAW_FIXED  = 39;
   localparam logic [7:0]  BLOCK_MAX  = 8'd254;
   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

   // fixed 29-byte text header following the length field
   function automatic logic [7:0] hdr_byte(input logic [4:0] k);
      logic [7:0] b;
      case (k)
         5'd0:    b = 8'h01;
         5'd1:    b = 8'h42;
         5'd2:    b = 8'h4F;
         5'd3:    b = 8'h4F;
         5'd4:    b = 8'h54;
         5'd5:    b = 8'h4C;
         5'd6:    b = 8'h4F;
         5'd7:    b = 8'h41;
         5'd8:    b = 8'h44;
         5'd9:    b = 8'h45;
         5'd10:   b = 8'h52;
         5'd17:   b = 8'h2A;
         5'd18:   b = 8'h2A;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[design/log_line_cobs_crc_framer_unit.sv]
// Log-line framer: collects characters, then sends a CRC-32 protected,
// COBS-encoded frame between 0x55 delimiters, one byte per tick.
//
// req channel (valid/ready): mode 0 character, 1 end of line, 2 tick.
// Every req transfer produces exactly one rsp transfer.
// rsp channel (valid/ready): out_valid/out_byte carry a stream byte on ticks,
// frame_end flags the closing delimiter, busy_res is high while a frame is
// in flight (chars and flushes then ignored), char_dropped flags a char lost to a full store.
//
// Characters, idle ticks and delimiters answer in the cycle after the
// transfer. A flush walks the raw frame once through the shared byte fetch
// and CRC step, a read state then a use state per raw byte. A COBS code
// byte scans ahead through the same fetch, a check and a use state per
// non-zero byte taken (up to 254), then an end state. A data byte passes a
// read state and a use state, as the message store read port is registered.
// One item is in work at a time; req_ready is low while the sequencer
// runs or a response is held. A stalled rsp simply holds the response.
// Reset (synchronous) empties the store and ends any frame; store contents
// are not cleared.
module log_line_cobs_crc_framer_unit #(
   parameter int MESSAGE_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lcf_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lcf_pkg::rsp_type rsp_payload
);

   localparam int CNT_W  = $clog2(MESSAGE_DEPTH + 1);
   localparam int ADDR_W = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
   localparam int IDX_W  = $clog2(MESSAGE_DEPTH + lcf_pkg::RAW_FIXED + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_CRC_RD, S_CRC_USE, S_SCAN_CHK, S_SCAN_USE, S_SCAN_END,
      S_DATA_RD, S_DATA_USE
   } state_type;

   typedef enum logic [2:0] {
      P_IDLE, P_OPEN, P_CODE, P_SHORT, P_FULL, P_CLOSE
   } phase_type;

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             sending_ff, sending_in;
   logic [IDX_W-1:0] rp_ff, rp_in;       // raw position
   logic [IDX_W-1:0] idx_ff, idx_in;     // fetch index
   logic [31:0]      crc_ff, crc_in;
   logic [7:0]       rem_ff, rem_in;     // block remaining
   logic [7:0]       scan_ff, scan_in;   // look-ahead count
   logic             rsp_valid_ff, rsp_valid_in;
   lcf_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0]        store [MESSAGE_DEPTH];
   logic [7:0]        mem_rd_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  rd_off;
   logic [ADDR_W-1:0] rd_addr;

   logic [IDX_W-1:0] raw_len, crc_at, crc_last;
   logic [15:0]      frame_len;
   logic [IDX_W-1:0] crc_off;
   logic [7:0]       raw_b;
   logic             accept, rsp_load;
   logic [IDX_W-1:0] rp_next;
   logic [7:0]       rem_next, code_b;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign raw_len   = IDX_W'(count_ff) + IDX_W'(lcf_pkg::RAW_FIXED);
   assign crc_at    = IDX_W'(count_ff) + IDX_W'(lcf_pkg::MSG_OFFSET);
   assign crc_last  = crc_at - IDX_W'(1);
   assign frame_len = 16'(count_ff) + 16'(lcf_pkg::LEN_BIAS);
   assign crc_off   = idx_ff - crc_at;
   assign rd_off    = idx_ff - IDX_W'(lcf_pkg::MSG_OFFSET);
   assign rd_addr   = rd_off[ADDR_W-1:0];

   // raw frame byte at idx_ff; store data arrives in the cycle after idx_ff is set
   always_comb begin
      if (idx_ff == IDX_W'(0))      raw_b = lcf_pkg::MAGIC_HI;
      else if (idx_ff == IDX_W'(1)) raw_b = lcf_pkg::MAGIC_LO;
      else if (idx_ff == IDX_W'(2)) raw_b = lcf_pkg::PROTO_HI;
      else if (idx_ff == IDX_W'(3)) raw_b = lcf_pkg::PROTO_LO;
      else if (idx_ff == IDX_W'(4)) raw_b = frame_len[15:8];
      else if (idx_ff == IDX_W'(5)) raw_b = frame_len[7:0];
      else if (idx_ff < IDX_W'(lcf_pkg::MSG_OFFSET))
         raw_b = lcf_pkg::hdr_byte(5'(idx_ff - IDX_W'(6)));
      else if (idx_ff < crc_at) raw_b = mem_rd_ff;
      else if (idx_ff < crc_at + IDX_W'(4)) begin
         case (crc_off[1:0])
            2'd0:    raw_b = crc_ff[7:0];
            2'd1:    raw_b = crc_ff[15:8];
            2'd2:    raw_b = crc_ff[23:16];
            default: raw_b = crc_ff[31:24];
         endcase
      end else raw_b = 8'h00;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[count_ff[ADDR_W-1:0]] <= req_payload.char_byte;
      end
      mem_rd_ff <= store[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      sending_in   = sending_ff;
      rp_in        = rp_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      rem_in       = rem_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rsp_load     = 1'b0;
      mem_we       = 1'b0;
      rp_next      = rp_ff + IDX_W'(1);
      rem_next     = (rem_ff != 8'd0) ? rem_ff - 8'd1 : rem_ff;
      code_b       = scan_ff + 8'd1;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in   = '0;
               rsp_load = 1'b1;
               case (req_payload.mode)
                  lcf_pkg::MODE_CHAR, lcf_pkg::MODE_EOL: begin
                     if (!sending_ff) begin
                        if (req_payload.mode == lcf_pkg::MODE_EOL ||
                            req_payload.char_byte == lcf_pkg::CH_LF) begin
                           rsp_load = 1'b0;
                           crc_in   = lcf_pkg::CRC_INIT;
                           idx_in   = '0;
                           state_in = S_CRC_RD;
                        end else if (req_payload.char_byte != lcf_pkg::CH_CR) begin
                           if (count_ff < CNT_W'(MESSAGE_DEPTH)) begin
                              mem_we   = 1'b1;
                              count_in = count_ff + CNT_W'(1);
                           end else begin
                              rsp_in.char_dropped = 1'b1;
                           end
                        end
                     end
                  end
                  lcf_pkg::MODE_TICK: begin
                     if (sending_ff) begin
                        case (phase_ff)
                           P_OPEN: begin
                              rsp_in.out_valid = 1'b1;
                              rsp_in.out_byte  = lcf_pkg::DELIM;
                              phase_in         = P_CODE;
                           end
                           P_CODE: begin
                              rsp_load = 1'b0;
                              idx_in   = rp_ff;
                              scan_in  = 8'd0;
                              state_in = S_SCAN_CHK;
                           end
                           P_SHORT, P_FULL: begin
                              rsp_load = 1'b0;
                              idx_in   = rp_ff;
                              state_in = S_DATA_RD;
                           end
                           default: begin
                              rsp_in.out_valid = 1'b1;
                              rsp_in.out_byte  = lcf_pkg::DELIM;
                              rsp_in.frame_end = 1'b1;
                              phase_in         = P_IDLE;
                              sending_in       = 1'b0;
                              count_in         = '0;
                              rp_in            = '0;
                           end
                        endcase
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CRC_RD: state_in = S_CRC_USE;
         S_CRC_USE: begin
            crc_in = lcf_pkg::crc_byte(crc_ff, raw_b);
            if (idx_ff == crc_last) begin
               crc_in     = ~lcf_pkg::crc_byte(crc_ff, raw_b);
               rp_in      = '0;
               rem_in     = 8'd0;
               sending_in = 1'b1;
               phase_in   = P_OPEN;
               rsp_in     = '0;
               rsp_load   = 1'b1;
               state_in   = S_IDLE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_CRC_RD;
            end
         end
         S_SCAN_CHK: begin
            if (scan_ff < lcf_pkg::BLOCK_MAX && idx_ff < raw_len) state_in = S_SCAN_USE;
            else state_in = S_SCAN_END;
         end
         S_SCAN_USE: begin
            if (raw_b != 8'h00) begin
               scan_in  = scan_ff + 8'd1;
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_SCAN_CHK;
            end else begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            rem_in = scan_ff;
            if (scan_ff == 8'd0) begin
               if (rp_ff >= raw_len) phase_in = P_CLOSE;
               else begin
                  rp_in    = rp_next;
                  phase_in = P_CODE;
               end
            end else begin
               phase_in = (scan_ff == lcf_pkg::BLOCK_MAX) ? P_FULL : P_SHORT;
            end
            rsp_in           = '0;
            rsp_in.out_valid = 1'b1;
            rsp_in.out_byte  = (code_b == lcf_pkg::DELIM) ? 8'h00 : code_b;
            rsp_load         = 1'b1;
            state_in         = S_IDLE;
         end
         S_DATA_RD: state_in = S_DATA_USE;
         S_DATA_USE: begin
            rp_in  = rp_next;
            rem_in = rem_next;
            if (rem_next == 8'd0) begin
               if (rp_next >= raw_len) phase_in = P_CLOSE;
               else begin
                  if (phase_ff != P_FULL) rp_in = rp_next + IDX_W'(1);
                  phase_in = P_CODE;
               end
            end
            rsp_in           = '0;
            rsp_in.out_valid = 1'b1;
            rsp_in.out_byte  = (raw_b == lcf_pkg::DELIM) ? 8'h00 : raw_b;
            rsp_load         = 1'b1;
            state_in         = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (rsp_load) begin
         rsp_in.busy_res = sending_in;
         rsp_valid_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= P_IDLE;
         count_ff     <= '0;
         sending_ff   <= 1'b0;
         rp_ff        <= '0;
         crc_ff       <= lcf_pkg::CRC_INIT;
         rem_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sending_ff   <= sending_in;
         rp_ff        <= rp_in;
         crc_ff       <= crc_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      scan_ff <= scan_in;
      rsp_ff  <= rsp_in;
   end

   // a response is only pending while the sequencer is idle
   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff) else $error("rsp pending while busy");

   a_phase_vs_sending: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> (phase_ff == P_IDLE)) else $error("phase active while idle");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MESSAGE_DEPTH)) else $error("message count overflow");

   a_block_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= lcf_pkg::BLOCK_MAX) else $error("block remaining out of range");

   a_flush_ends_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CRC_USE && idx_ff == crc_last) |=> sending_ff)
      else $error("flush did not start a frame");

endmodule
